// ----- src/cfp_pkg.sv -----
// Shared types, constants and helper functions for the IMU complementary filter.
`timescale 1ns / 1ps
package cfp_pkg;

    // Register reset values and register indexes
    localparam logic [15:0] ALPHA_RESET = 16'd64225;
    localparam logic [15:0] DT_RESET    = 16'd655;
    localparam logic        CFG_BLEND   = 1'b0;
    localparam logic        CFG_STEP    = 1'b1;

    // Sequencing
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int CNT_W            = 5;
    localparam int SQRT_STEPS       = 32;
    localparam int LANE_W           = 4;
    localparam logic [LANE_W-1:0] LANE_PITCH = 4'd0;
    localparam logic [LANE_W-1:0] LANE_ROLL  = 4'd1;
    localparam logic [LANE_W-1:0] LANE_YAW   = 4'd2;
    localparam logic [LANE_W-1:0] LANE_SM0   = 4'd3;
    localparam logic [LANE_W-1:0] LANE_LAST  = 4'd8;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pitch_angle;
        logic signed [31:0] roll_angle;
        logic signed [31:0] yaw_angle;
        logic signed [31:0] smooth_accel_x;
        logic signed [31:0] smooth_accel_y;
        logic signed [31:0] smooth_accel_z;
        logic signed [31:0] smooth_gyro_x;
        logic signed [31:0] smooth_gyro_y;
        logic signed [31:0] smooth_gyro_z;
    } t_out_word;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_CD_INIT,
        OP_CD_STEP,
        OP_GYRO,
        OP_GADD,
        OP_YAW,
        OP_MUL_OLD,
        OP_MUL_NEW,
        OP_WRITE,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              sel;   // 0: pitch angle, 1: roll angle
        logic [CNT_W-1:0]  cnt;   // iteration index
        logic [LANE_W-1:0] lane;  // blend lane
    } t_cmd;

    // atan(2^-i) in degrees, Q16.16, rounded
    function automatic logic signed [31:0] atan_deg(input logic [CNT_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117304;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sh0080000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- src/cfp_ctrl.sv -----
// Sequencer for the filter: runs square root, CORDIC and blend steps per word.
`timescale 1ns / 1ps
module cfp_ctrl #(
    parameter int CORDIC_STEPS = cfp_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cfp_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_INIT,
        S_SQ_STEP,
        S_CD_INIT,
        S_CD_STEP,
        S_GYRO,
        S_GADD,
        S_YAW,
        S_MUL_OLD,
        S_MUL_NEW,
        S_WRITE,
        S_DONE
    } t_state;

    localparam logic [cfp_pkg::CNT_W-1:0] CD_LAST = cfp_pkg::CNT_W'(CORDIC_STEPS - 1);
    localparam logic [cfp_pkg::CNT_W-1:0] SQ_LAST = cfp_pkg::CNT_W'(cfp_pkg::SQRT_STEPS - 1);

    t_state                        r_state;
    logic                          r_sel;
    logic [cfp_pkg::CNT_W-1:0]     r_cnt;
    logic [cfp_pkg::LANE_W-1:0]    r_lane;
    logic                          r_out_valid;
    logic                          w_out_load;
    cfp_pkg::t_op                  w_op;

    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Operation decode
    always_comb begin
        case (r_state)
            S_SQ_INIT: w_op = cfp_pkg::OP_SQ_INIT;
            S_SQ_STEP: w_op = cfp_pkg::OP_SQ_STEP;
            S_CD_INIT: w_op = cfp_pkg::OP_CD_INIT;
            S_CD_STEP: w_op = cfp_pkg::OP_CD_STEP;
            S_GYRO:    w_op = cfp_pkg::OP_GYRO;
            S_GADD:    w_op = cfp_pkg::OP_GADD;
            S_YAW:     w_op = cfp_pkg::OP_YAW;
            S_MUL_OLD: w_op = cfp_pkg::OP_MUL_OLD;
            S_MUL_NEW: w_op = cfp_pkg::OP_MUL_NEW;
            S_WRITE:   w_op = cfp_pkg::OP_WRITE;
            S_DONE:    w_op = w_out_load ? cfp_pkg::OP_OUT : cfp_pkg::OP_NONE;
            default:   w_op = cfp_pkg::OP_NONE;
        endcase
    end

    assign o_cmd = '{op: w_op, sel: r_sel, cnt: r_cnt, lane: r_lane};

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= 1'b0;
            r_cnt       <= '0;
            r_lane      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sel   <= 1'b0;
                        r_state <= S_SQ_INIT;
                    end
                end
                S_SQ_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_SQ_STEP;
                end
                S_SQ_STEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SQ_LAST) begin
                        r_state <= S_CD_INIT;
                    end
                end
                S_CD_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_CD_STEP;
                end
                S_CD_STEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CD_LAST) begin
                        if (!r_sel) begin
                            r_sel   <= 1'b1;
                            r_state <= S_SQ_INIT;
                        end else begin
                            r_lane  <= cfp_pkg::LANE_PITCH;
                            r_state <= S_GYRO;
                        end
                    end
                end
                S_GYRO: r_state <= S_GADD;
                S_GADD: begin
                    r_state <= (r_lane == cfp_pkg::LANE_YAW) ? S_YAW : S_MUL_OLD;
                end
                S_YAW: begin
                    r_lane  <= cfp_pkg::LANE_SM0;
                    r_state <= S_MUL_OLD;
                end
                S_MUL_OLD: r_state <= S_MUL_NEW;
                S_MUL_NEW: r_state <= S_WRITE;
                S_WRITE: begin
                    if (r_lane == cfp_pkg::LANE_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lane  <= r_lane + 1'b1;
                        r_state <= (r_lane < cfp_pkg::LANE_YAW) ? S_GYRO : S_MUL_OLD;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/cfp_datapath.sv -----
// Filter datapath: input latch, bit-serial root, CORDIC, shared blend multiplier, state.
`timescale 1ns / 1ps
module cfp_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  cfp_pkg::t_in_word   i_in_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [15:0]         i_cfg_data,
    input  cfp_pkg::t_cmd       i_cmd,
    output cfp_pkg::t_out_word  o_out_word
);

    cfp_pkg::t_in_word   r_in;
    cfp_pkg::t_out_word  r_out;
    logic [15:0]         r_alpha;
    logic [15:0]         r_dt;

    logic [31:0]         r_rad;
    logic [33:0]         r_rem;
    logic [31:0]         r_root;
    logic signed [35:0]  r_x;
    logic signed [35:0]  r_y;
    logic signed [31:0]  r_ang [2];

    logic signed [51:0]  r_prod;
    logic signed [51:0]  r_acc;
    logic signed [33:0]  r_old;
    logic signed [31:0]  r_est [3];
    logic signed [31:0]  r_sm [6];

    logic signed [15:0]  w_v [6];
    logic signed [15:0]  w_a;
    logic signed [15:0]  w_b;
    logic [31:0]         w_sq;
    logic [35:0]         w_remx;
    logic [35:0]         w_trial;
    logic signed [35:0]  w_xs;
    logic signed [35:0]  w_ys;
    logic [2:0]          w_sm_idx;
    logic [1:0]          w_est_idx;
    logic [2:0]          w_gyro_idx;
    logic signed [33:0]  w_old;
    logic signed [31:0]  w_fresh;
    logic signed [17:0]  w_wnew;
    logic signed [52:0]  w_sum;
    logic signed [31:0]  w_blend;

    assign w_v[0] = r_in.accel_x;
    assign w_v[1] = r_in.accel_y;
    assign w_v[2] = r_in.accel_z;
    assign w_v[3] = r_in.gyro_x;
    assign w_v[4] = r_in.gyro_y;
    assign w_v[5] = r_in.gyro_z;

    // Angle operands: pitch uses ax over (ay, az), roll uses ay over (ax, az)
    assign w_a  = i_cmd.sel ? r_in.accel_y : r_in.accel_x;
    assign w_b  = i_cmd.sel ? r_in.accel_x : r_in.accel_y;
    assign w_sq = 32'(32'(w_b) * 32'(w_b)) + 32'(32'(r_in.accel_z) * 32'(r_in.accel_z));

    // Root digit trial
    assign w_remx  = {r_rem, r_rad[31:30]};
    assign w_trial = {2'b00, r_root, 2'b01};

    // CORDIC shifts
    assign w_xs = r_x >>> i_cmd.cnt;
    assign w_ys = r_y >>> i_cmd.cnt;

    // Blend operands
    assign w_sm_idx   = 3'(i_cmd.lane - cfp_pkg::LANE_SM0);
    assign w_est_idx  = i_cmd.lane[1:0];
    assign w_gyro_idx = 3'd3 + {1'b0, w_est_idx};
    assign w_old      = (i_cmd.lane < cfp_pkg::LANE_YAW) ? r_old : 34'(r_sm[w_sm_idx]);
    always_comb begin
        if (i_cmd.lane == cfp_pkg::LANE_PITCH) begin
            w_fresh = r_ang[0];
        end else if (i_cmd.lane == cfp_pkg::LANE_ROLL) begin
            w_fresh = r_ang[1];
        end else begin
            w_fresh = {w_v[w_sm_idx], 16'h0000};
        end
    end
    assign w_wnew  = 18'sh10000 - $signed({2'b00, r_alpha});
    assign w_sum   = 53'(r_acc) + 53'(r_prod) + 53'sd32768;
    assign w_blend = cfp_pkg::sat32(40'(w_sum >>> 16));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= cfp_pkg::ALPHA_RESET;
            r_dt    <= cfp_pkg::DT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == cfp_pkg::CFG_BLEND) begin
                r_alpha <= i_cfg_data;
            end else begin
                r_dt <= i_cfg_data;
            end
        end
    end

    // Filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_est[k] <= '0;
            for (int k = 0; k < 6; k++) r_sm[k] <= '0;
        end else begin
            case (i_cmd.op)
                cfp_pkg::OP_YAW: r_est[2] <= cfp_pkg::sat32(40'(r_old));
                cfp_pkg::OP_WRITE: begin
                    if (i_cmd.lane < cfp_pkg::LANE_YAW) begin
                        r_est[w_est_idx] <= w_blend;
                    end else begin
                        r_sm[w_sm_idx] <= w_blend;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in <= i_in_word;
        end
        case (i_cmd.op)
            cfp_pkg::OP_SQ_INIT: begin
                r_rad  <= w_sq;
                r_rem  <= '0;
                r_root <= '0;
            end
            cfp_pkg::OP_SQ_STEP: begin
                r_rad <= {r_rad[29:0], 2'b00};
                if (w_remx >= w_trial) begin
                    r_rem  <= 34'(w_remx - w_trial);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= 34'(w_remx);
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            cfp_pkg::OP_CD_INIT: begin
                r_x            <= $signed({4'b0000, r_root});
                r_y            <= $signed({{4{w_a[15]}}, w_a, 16'h0000});
                r_ang[i_cmd.sel] <= '0;
            end
            cfp_pkg::OP_CD_STEP: begin
                if (!r_y[35] && (r_y != '0)) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_ang[i_cmd.sel] <= r_ang[i_cmd.sel] + cfp_pkg::atan_deg(i_cmd.cnt);
                end else if (r_y[35]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_ang[i_cmd.sel] <= r_ang[i_cmd.sel] - cfp_pkg::atan_deg(i_cmd.cnt);
                end
            end
            cfp_pkg::OP_GYRO: begin
                r_prod <= 52'(w_v[w_gyro_idx] * $signed({1'b0, r_dt}));
            end
            cfp_pkg::OP_GADD: begin
                r_old <= 34'(r_est[w_est_idx]) + 34'($signed(r_prod[32:0]));
            end
            cfp_pkg::OP_MUL_OLD: begin
                r_prod <= 52'($signed({1'b0, r_alpha}) * w_old);
            end
            cfp_pkg::OP_MUL_NEW: begin
                r_acc  <= r_prod;
                r_prod <= 52'(w_wnew * w_fresh);
            end
            cfp_pkg::OP_OUT: begin
                r_out.pitch_angle    <= r_est[0];
                r_out.roll_angle     <= r_est[1];
                r_out.yaw_angle      <= r_est[2];
                r_out.smooth_accel_x <= r_sm[0];
                r_out.smooth_accel_y <= r_sm[1];
                r_out.smooth_accel_z <= r_sm[2];
                r_out.smooth_gyro_x  <= r_sm[3];
                r_out.smooth_gyro_y  <= r_sm[4];
                r_out.smooth_gyro_z  <= r_sm[5];
            end
            default: ;
        endcase
    end

    assign o_out_word = r_out;

endmodule

// ----- src/imu_complementary_filter_core.sv -----
// Top level of the six-axis IMU complementary pitch/roll filter.
`timescale 1ns / 1ps
// One word in gives one result word out. Per angle a bit-serial square root and a
// CORDIC of CORDIC_STEPS iterations share one unit each; then yaw is integrated
// and eight blend lanes run through one shared multiplier. The input stalls while
// a word is in work; a finished result sits in the output register, so the next
// word is taken while it waits. The user must write registers only while the
// block is idle; the block itself does not enforce it. Index 0 is alpha (Q0.16),
// index 1 is dt (Q0.16).
module imu_complementary_filter_core #(
    parameter int CORDIC_STEPS = cfp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cfp_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cfp_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_addr,
    input  logic [15:0]         i_cfg_data
);

    cfp_pkg::t_cmd w_cmd;
    logic          w_load;

    assign w_load = i_in_valid && !o_in_stall;

    cfp_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    cfp_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_out_word (o_out_word)
    );

    // A taken word keeps the block busy on the next cycle
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_in_stall)
        else $error("input not stalled after word taken");

    // Loading the output register raises valid
    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == cfp_pkg::OP_OUT) |=> o_out_valid)
        else $error("result loaded but valid low");

    // No datapath work while the input is open
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (w_cmd.op == cfp_pkg::OP_NONE))
        else $error("datapath busy while input open");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the IMU complementary filter core.
`timescale 1ns / 1ps
module testbench;

    localparam int TRIG_STEPS = 16;
    localparam int DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    cfp_pkg::t_in_word   i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    cfp_pkg::t_out_word  o_out_word;
    logic                i_cfg_we;
    logic                i_cfg_addr;
    logic [15:0]         i_cfg_data;

    imu_complementary_filter_core #(.CORDIC_STEPS(TRIG_STEPS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    // Filter state mirrored by the predictor
    logic [15:0]        alpha_q;
    logic [15:0]        dt_q;
    logic signed [31:0] pitch_q, roll_q, yaw_q;
    logic signed [31:0] smooth_q [6];

    cfp_pkg::t_out_word expected_words [$];
    int                 error_count;
    longint             cycle_count;
    bit                 no_idle;

    const logic signed [31:0] ATAN_TAB [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
        if (v < -64'sh80000000) return -64'sh80000000;
        return v;
    endfunction

    // floor(sqrt(n)) by digit recurrence
    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // atan2(a, sqrt(b^2+c^2)) in degrees Q16.16 via vectoring CORDIC
    function automatic logic signed [63:0] tilt_deg(input logic signed [63:0] a,
            input logic signed [63:0] b, input logic signed [63:0] c);
        logic [63:0]        sumsq;
        logic signed [63:0] x, y, z, xs, ys;
        sumsq = 64'(b * b) + 64'(c * c);
        x = $signed(root64(sumsq << 32));
        y = a * 65536;
        z = 0;
        for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
            end else if (y < 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic logic signed [31:0] mix(input logic signed [63:0] prev,
            input logic signed [63:0] fresh);
        logic signed [63:0] a, acc;
        a = {48'd0, alpha_q};
        acc = a * prev + (64'sd65536 - a) * fresh + 64'sd32768;
        return 32'(clamp32(acc >>> 16));
    endfunction

    // Advance the filter model by one sample and queue the expected word
    function automatic void predict_filter(input cfp_pkg::t_in_word w);
        logic signed [63:0] v [6];
        logic signed [63:0] dt, ap, ar;
        cfp_pkg::t_out_word r;
        v[0] = w.accel_x; v[1] = w.accel_y; v[2] = w.accel_z;
        v[3] = w.gyro_x;  v[4] = w.gyro_y;  v[5] = w.gyro_z;
        dt = {48'd0, dt_q};
        ap = tilt_deg(v[0], v[1], v[2]);
        ar = tilt_deg(v[1], v[0], v[2]);
        pitch_q = mix(pitch_q + v[3] * dt, ap);
        roll_q  = mix(roll_q + v[4] * dt, ar);
        yaw_q   = 32'(clamp32(yaw_q + v[5] * dt));
        for (int i = 0; i < 6; i++) smooth_q[i] = mix(smooth_q[i], v[i] * 65536);
        r.pitch_angle = pitch_q; r.roll_angle = roll_q; r.yaw_angle = yaw_q;
        r.smooth_accel_x = smooth_q[0]; r.smooth_accel_y = smooth_q[1];
        r.smooth_accel_z = smooth_q[2]; r.smooth_gyro_x = smooth_q[3];
        r.smooth_gyro_y = smooth_q[4]; r.smooth_gyro_z = smooth_q[5];
        expected_words.push_back(r);
    endfunction

    // Random output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(99) < 18);
        end
    end

    task automatic report(input string name, input logic [31:0] exp_v,
            input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        cfp_pkg::t_out_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word expected none actual %h", $time, o_out_word);
                error_count++;
            end else begin
                e = expected_words.pop_front();
                report("pitch", e.pitch_angle, o_out_word.pitch_angle);
                report("roll", e.roll_angle, o_out_word.roll_angle);
                report("yaw", e.yaw_angle, o_out_word.yaw_angle);
                report("smooth_ax", e.smooth_accel_x, o_out_word.smooth_accel_x);
                report("smooth_ay", e.smooth_accel_y, o_out_word.smooth_accel_y);
                report("smooth_az", e.smooth_accel_z, o_out_word.smooth_accel_z);
                report("smooth_gx", e.smooth_gyro_x, o_out_word.smooth_gyro_x);
                report("smooth_gy", e.smooth_gyro_y, o_out_word.smooth_gyro_y);
                report("smooth_gz", e.smooth_gyro_z, o_out_word.smooth_gyro_z);
            end
        end
    end

    // Send one sample; random idle cycles before it. Valid stays up after the
    // accepting edge until the next send, an idle cycle or a drain drops it.
    task automatic send_sample(input cfp_pkg::t_in_word w);
        while (!no_idle && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        predict_filter(w);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_fields(input int ax, input int ay, input int az,
            input int gx, input int gy, input int gz);
        cfp_pkg::t_in_word w;
        w.accel_x = 16'(ax); w.accel_y = 16'(ay); w.accel_z = 16'(az);
        w.gyro_x = 16'(gx); w.gyro_y = 16'(gy); w.gyro_z = 16'(gz);
        send_sample(w);
    endtask

    function automatic cfp_pkg::t_in_word random_sample();
        cfp_pkg::t_in_word w;
        w = cfp_pkg::t_in_word'({$urandom, $urandom, $urandom});
        // often a plausible gravity vector with small rates
        if ($urandom_range(1)) begin
            w.accel_x = 16'($signed($urandom_range(8000)) - 4000);
            w.accel_y = 16'($signed($urandom_range(8000)) - 4000);
            w.accel_z = 16'($signed($urandom_range(4000)) + 14000);
            w.gyro_x  = 16'($signed($urandom_range(400)) - 200);
            w.gyro_y  = 16'($signed($urandom_range(400)) - 200);
        end
        return w;
    endfunction

    // Wait until every expected word has come, then for the pipeline to settle
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write, followed by a quiet cycle
    task automatic write_reg(input logic addr, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == cfp_pkg::CFG_BLEND) alpha_q = data;
        else dt_q = data;
        @(posedge i_clk);
    endtask

    // Extremes, zero vector, zero root and saturating gyro
    task automatic test_directed();
        send_fields(0, 0, 0, 0, 0, 0);
        send_fields(1000, 0, 0, 0, 0, 0);
        send_fields(-1000, 0, 0, 0, 0, 0);
        send_fields(0, 32767, 0, 0, 0, 0);
        send_fields(0, -32768, 0, 0, 0, 0);
        send_fields(32767, 32767, 32767, 32767, 32767, 32767);
        send_fields(-32768, -32768, -32768, -32768, -32768, -32768);
        send_fields(-32768, 32767, -32768, 32767, -32768, 32767);
        send_fields(0, 0, 16384, 100, -100, 5);
        send_fields(16384, 16384, 0, -1, 1, -1);
    endtask

    // Drive yaw to both saturation limits with large dt
    task automatic test_saturation();
        write_reg(cfp_pkg::CFG_STEP, 16'hFFFF);
        write_reg(cfp_pkg::CFG_BLEND, 16'd0);
        repeat (5) send_fields(-32768, 100, -5, 32767, 32767, 32767);
        repeat (10) send_fields(32767, -100, 5, -32768, -32768, -32768);
        wait_drain();
        write_reg(cfp_pkg::CFG_BLEND, 16'hFFFF);
        repeat (5) send_fields(123, -456, 789, 32767, -32768, 32767);
        wait_drain();
        write_reg(cfp_pkg::CFG_STEP, 16'd0);
        write_reg(cfp_pkg::CFG_BLEND, 16'd32768);
        repeat (3) send_fields(500, 500, -500, 32767, 32767, -32768);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            // one stretch without any idling
            no_idle = (i >= count / 3 && i < count / 2);
            send_sample(random_sample());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = cfp_pkg::CFG_BLEND;
        i_cfg_data  = '0;
        alpha_q = cfp_pkg::ALPHA_RESET;
        dt_q    = cfp_pkg::DT_RESET;
        pitch_q = 0; roll_q = 0; yaw_q = 0;
        for (int i = 0; i < 6; i++) smooth_q[i] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drain();
        test_saturation();
        wait_drain();
        write_reg(cfp_pkg::CFG_BLEND, cfp_pkg::ALPHA_RESET);
        write_reg(cfp_pkg::CFG_STEP, 16'd1);
        test_random(250);
        wait_drain();
        write_reg(cfp_pkg::CFG_BLEND, 16'($urandom));
        write_reg(cfp_pkg::CFG_STEP, 16'($urandom_range(65535, 1)));
        test_random(250);
        wait_drain();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
src/cfp_pkg.sv
src/cfp_ctrl.sv
src/cfp_datapath.sv
src/imu_complementary_filter_core.sv
tb/testbench.sv
